@@ rtl/bf_pkg.sv @@
package bf_pkg;

   // Image geometry and datapath sizes.
   localparam int MAX_WIDTH     = 2048;
   localparam int PIXEL_BITS    = 8;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS    = 12;
   localparam int HEIGHT_BITS   = 16;
   localparam int COLSUM_BITS   = PIXEL_BITS + 2;
   localparam int SUM_BITS      = PIXEL_BITS + 4;
   localparam int FRAC_BITS     = 16;
   localparam int RECIP_BITS    = FRAC_BITS + 1;
   localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;
   localparam int CNT_BITS      = 4;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [0:0] {
      KIND_PIXEL,
      KIND_DRAIN
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [PIXEL_BITS-1:0]   pixel;
   } item_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]   smoothed_value;
      logic                    image_last;
   } result_type;

   typedef struct packed {
      logic                    push_a;
      logic                    push_b;
      result_type              res_a;
      result_type              res_b;
   } push_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]   top;
      logic [PIXEL_BITS-1:0]   mid;
      logic [PIXEL_BITS-1:0]   bot;
   } column_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIX_CALC,
      ST_DR_MID,
      ST_DR_LEFT,
      ST_DR_RIGHT,
      ST_EMIT
   } state_type;

   // Scaled reciprocal of the neighbor count; exact floor for sums up to 9 * 255.
   function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] n);
      logic [RECIP_BITS-1:0] r;
      case (n)
         4'd1:    r = RECIP_BITS'(65536);
         4'd2:    r = RECIP_BITS'(32768);
         4'd3:    r = RECIP_BITS'(21846);
         4'd4:    r = RECIP_BITS'(16384);
         4'd6:    r = RECIP_BITS'(10923);
         4'd9:    r = RECIP_BITS'(7282);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Sum of one window column, with the top row left out above the image.
   function automatic logic [COLSUM_BITS-1:0] colsum(input column_type col,
                                                     input logic use_top);
      logic [COLSUM_BITS-1:0] s;
      s = COLSUM_BITS'(col.mid) + COLSUM_BITS'(col.bot);
      if (use_top) begin
         s = s + COLSUM_BITS'(col.top);
      end
      return s;
   endfunction

endpackage

@@ rtl/bf_req_if.sv @@
interface bf_req_if import bf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [PIXEL_BITS-1:0] pixel_value;

   modport source (output valid, func, pixel_value, input ready);
   modport sink   (input valid, func, pixel_value, output ready);
endinterface

@@ rtl/bf_rsp_if.sv @@
interface bf_rsp_if import bf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] smoothed_value;
   logic                  image_last;

   modport source (output valid, smoothed_value, image_last, input ready);
   modport sink   (input valid, smoothed_value, image_last, output ready);
endinterface

@@ rtl/bf_csr_if.sv @@
interface bf_csr_if import bf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] addr;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

@@ rtl/bf_front.sv @@
module bf_front import bf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bf_req_if.sink    req_chan,
   output logic      q_valid,
   output item_type  q_item,
   input  logic      q_pop
);

   item_type    ent_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   item_type    new_item;

   // Classify the incoming transaction as a pixel or a drain step.
   always_comb begin
      new_item.kind  = req_chan.func ? KIND_DRAIN : KIND_PIXEL;
      new_item.pixel = req_chan.pixel_value;
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign q_item         = ent_ff[rd_ptr_ff];

   // Queue pointer and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/bf_engine.sv @@
module bf_engine import bf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bf_csr_if.sink    csr_chan,
   input  logic      q_valid,
   input  item_type  q_item,
   output logic      q_pop,
   input  logic      out_empty,
   output push_type  push
);

   // Configuration and image position.
   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0]    drain_ff, drain_in;
   logic                   draining_ff, draining_in;
   state_type              state_ff, state_in;
   column_type             win_ff [3];

   // Datapath registers.
   logic [PIXEL_BITS-1:0]  pix_ff;
   logic [SUM_BITS-1:0]    acc_ff;
   logic [SUM_BITS-1:0]    sum_a_ff, sum_b_ff;
   logic [RECIP_BITS-1:0]  rec_a_ff, rec_b_ff;
   logic                   va_ff, vb_ff, last_a_ff;

   // Line stores.
   logic [PIXEL_BITS-1:0]  older_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0]  newer_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0]  older_q_ff, newer_q_ff;
   logic [COL_BITS-1:0]    rd_addr;

   // Control strobes.
   logic csr_wr, take, pix_go, dr_go;
   logic do_pix, do_dr_mid, do_dr_left, do_dr_right, do_emit;

   // Derived geometry.
   logic [WIDTH_BITS-1:0]  w_eff;
   logic [COL_BITS-1:0]    w_m1;
   logic [HEIGHT_BITS-1:0] h_m1;
   logic                   w_ge2, h_ge2, r_ge1, r_ge2, c_ge1, c_ge2, c_last;
   logic                   d_left, d_right;
   column_type             new_col;
   logic [SUM_BITS-1:0]    sum_a, sum_b, dr_sum;
   logic [1:0]             nrows, ncols_a, ncols_b, dr_rows, dr_cols;
   logic [PROD_BITS-1:0]   prod_a, prod_b;

   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (width_ff > WIDTH_BITS'(MAX_WIDTH)) begin
         w_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
   end

   assign w_m1    = COL_BITS'(w_eff - WIDTH_BITS'(1));
   assign w_ge2   = (w_eff >= WIDTH_BITS'(2));
   assign h_m1    = (height_ff == '0) ? '0 : height_ff - HEIGHT_BITS'(1);
   assign h_ge2   = (height_ff >= HEIGHT_BITS'(2));
   assign r_ge1   = (row_ff != '0);
   assign r_ge2   = (row_ff >= HEIGHT_BITS'(2));
   assign c_ge1   = (col_ff != '0);
   assign c_ge2   = (col_ff >= COL_BITS'(2));
   assign c_last  = (col_ff == w_m1);
   assign d_left  = (drain_ff != '0);
   assign d_right = (drain_ff != w_m1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_empty) begin
               if (q_item.kind == KIND_PIXEL && !draining_ff) begin
                  state_in = ST_PIX_CALC;
               end else if (q_item.kind == KIND_DRAIN && draining_ff) begin
                  state_in = ST_DR_MID;
               end
            end
         end
         ST_PIX_CALC: state_in = ST_EMIT;
         ST_DR_MID:   state_in = ST_DR_LEFT;
         ST_DR_LEFT:  state_in = ST_DR_RIGHT;
         ST_DR_RIGHT: state_in = ST_EMIT;
         ST_EMIT:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // State outputs: strobes and the line store read address.
   always_comb begin
      take        = 1'b0;
      do_pix      = 1'b0;
      do_dr_mid   = 1'b0;
      do_dr_left  = 1'b0;
      do_dr_right = 1'b0;
      do_emit     = 1'b0;
      rd_addr     = drain_ff;
      case (state_ff)
         ST_IDLE: begin
            take    = q_valid && out_empty;
            rd_addr = (q_item.kind == KIND_PIXEL) ? col_ff : drain_ff;
         end
         ST_PIX_CALC: do_pix = 1'b1;
         ST_DR_MID: begin
            do_dr_mid = 1'b1;
            rd_addr   = drain_ff - COL_BITS'(1);
         end
         ST_DR_LEFT: begin
            do_dr_left = 1'b1;
            rd_addr    = drain_ff + COL_BITS'(1);
         end
         ST_DR_RIGHT: do_dr_right = 1'b1;
         ST_EMIT:     do_emit     = 1'b1;
         default:     take        = 1'b0;
      endcase
   end

   assign q_pop  = take;
   assign pix_go = take && (q_item.kind == KIND_PIXEL) && !draining_ff;
   assign dr_go  = take && (q_item.kind == KIND_DRAIN) && draining_ff;

   // Neighborhood sums for a pixel step.
   always_comb begin
      new_col.top = older_q_ff;
      new_col.mid = newer_q_ff;
      new_col.bot = pix_ff;
      sum_a = SUM_BITS'(colsum(win_ff[0], r_ge2)) + SUM_BITS'(colsum(new_col, r_ge2));
      if (c_ge2) begin
         sum_a = sum_a + SUM_BITS'(colsum(win_ff[1], r_ge2));
      end
      sum_b = SUM_BITS'(colsum(new_col, r_ge2));
      if (w_ge2) begin
         sum_b = sum_b + SUM_BITS'(colsum(win_ff[0], r_ge2));
      end
      nrows   = r_ge2 ? 2'd3 : 2'd2;
      ncols_a = c_ge2 ? 2'd3 : 2'd2;
      ncols_b = w_ge2 ? 2'd2 : 2'd1;
   end

   // Drain step: columns are summed one store read at a time.
   always_comb begin
      dr_rows = h_ge2 ? 2'd2 : 2'd1;
      dr_cols = 2'd1 + {1'b0, d_left} + {1'b0, d_right};
      dr_sum  = acc_ff;
      if (d_right) begin
         dr_sum = acc_ff + SUM_BITS'(newer_q_ff);
         if (h_ge2) begin
            dr_sum = dr_sum + SUM_BITS'(older_q_ff);
         end
      end
   end

   // Position counters and configuration registers.
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      draining_in = draining_ff;
      if (csr_wr) begin
         case (csr_chan.addr)
            CSR_IMAGE_WIDTH:  width_in  = csr_chan.data[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_chan.data[HEIGHT_BITS-1:0];
            default:          width_in  = width_ff;
         endcase
         col_in      = '0;
         row_in      = '0;
         drain_in    = '0;
         draining_in = 1'b0;
      end else if (do_pix) begin
         if (c_last) begin
            col_in = '0;
            if (row_ff >= h_m1) begin
               row_in      = '0;
               draining_in = 1'b1;
               drain_in    = '0;
            end else begin
               row_in = row_ff + HEIGHT_BITS'(1);
            end
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end else if (do_dr_right) begin
         if (drain_ff >= w_m1) begin
            draining_in = 1'b0;
            drain_in    = '0;
         end else begin
            drain_in = drain_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_BITS'(1);
         height_ff   <= HEIGHT_BITS'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         draining_ff <= 1'b0;
         state_ff    <= ST_IDLE;
         va_ff       <= 1'b0;
         vb_ff       <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         draining_ff <= draining_in;
         state_ff    <= state_in;
         if (csr_wr) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i] <= '0;
            end
         end else if (do_pix) begin
            win_ff[2] <= win_ff[1];
            win_ff[1] <= win_ff[0];
            win_ff[0] <= new_col;
         end
         if (do_pix) begin
            va_ff <= r_ge1 && c_ge1;
            vb_ff <= r_ge1 && c_last;
         end else if (do_dr_right) begin
            va_ff <= 1'b1;
            vb_ff <= 1'b0;
         end
      end
   end

   // Sum and reciprocal registers in front of the multipliers.
   always_ff @(posedge clock) begin
      if (pix_go || dr_go) begin
         pix_ff <= q_item.pixel;
      end
      if (do_dr_mid) begin
         acc_ff <= SUM_BITS'(newer_q_ff) + (h_ge2 ? SUM_BITS'(older_q_ff) : '0);
      end else if (do_dr_left && d_left) begin
         acc_ff <= acc_ff + SUM_BITS'(newer_q_ff) + (h_ge2 ? SUM_BITS'(older_q_ff) : '0);
      end
      if (do_pix) begin
         sum_a_ff  <= sum_a;
         sum_b_ff  <= sum_b;
         rec_a_ff  <= recip(CNT_BITS'(nrows) * CNT_BITS'(ncols_a));
         rec_b_ff  <= recip(CNT_BITS'(nrows) * CNT_BITS'(ncols_b));
         last_a_ff <= 1'b0;
      end else if (do_dr_right) begin
         sum_a_ff  <= dr_sum;
         rec_a_ff  <= recip(CNT_BITS'(dr_rows) * CNT_BITS'(dr_cols));
         last_a_ff <= (drain_ff == w_m1);
      end
   end

   // Line stores: one shared read address, write during the pixel step.
   always_ff @(posedge clock) begin
      older_q_ff <= older_mem[rd_addr];
      newer_q_ff <= newer_mem[rd_addr];
      if (do_pix) begin
         older_mem[col_ff] <= newer_q_ff;
         newer_mem[col_ff] <= pix_ff;
      end
   end

   // Mean by reciprocal multiply, handed to the result buffer.
   assign prod_a = PROD_BITS'(sum_a_ff) * PROD_BITS'(rec_a_ff);
   assign prod_b = PROD_BITS'(sum_b_ff) * PROD_BITS'(rec_b_ff);

   always_comb begin
      push.push_a               = do_emit && va_ff;
      push.push_b               = do_emit && vb_ff;
      push.res_a.smoothed_value = prod_a[FRAC_BITS+PIXEL_BITS-1:FRAC_BITS];
      push.res_a.image_last     = last_a_ff;
      push.res_b.smoothed_value = prod_b[FRAC_BITS+PIXEL_BITS-1:FRAC_BITS];
      push.res_b.image_last     = 1'b0;
   end

endmodule

@@ rtl/bf_out.sv @@
module bf_out import bf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   bf_rsp_if.source  rsp_chan,
   output logic      empty
);

   result_type  ent_ff [2];
   logic        head_ff;
   logic [1:0]  count_ff;
   logic        pop;

   // The engine only starts an item with this buffer empty, so pushes
   // always land in an empty buffer.
   assign empty                   = (count_ff == 2'd0);
   assign rsp_chan.valid          = !empty;
   assign rsp_chan.smoothed_value = ent_ff[head_ff].smoothed_value;
   assign rsp_chan.image_last     = ent_ff[head_ff].image_last;
   assign pop                     = rsp_chan.valid && rsp_chan.ready;

   // Head pointer and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else if (push.push_a || push.push_b) begin
         head_ff  <= 1'b0;
         count_ff <= {1'b0, push.push_a} + {1'b0, push.push_b};
      end else if (pop) begin
         head_ff  <= ~head_ff;
         count_ff <= count_ff - 2'd1;
      end
   end

   // Result storage, first result in entry zero.
   always_ff @(posedge clock) begin
      if (push.push_a) begin
         ent_ff[0] <= push.res_a;
         if (push.push_b) begin
            ent_ff[1] <= push.res_b;
         end
      end else if (push.push_b) begin
         ent_ff[0] <= push.res_b;
      end
   end

endmodule

@@ rtl/box_filter_3x3_edge_mean_core.sv @@
// 3x3 box blur over a raster stream of 8-bit pixels, edge-trimmed mean.
// req_chan carries one transaction per pixel (func 0) or drain step (func 1).
// rsp_chan returns smoothed pixels; image_last marks the image's final pixel.
// csr_chan writes image_width (index 0) and image_height (index 1); a write
// restarts the image and is meant only while the block is idle.
// A two-entry input queue takes transactions while the engine works.
// The engine runs one transaction at a time over a single-port read of the
// two line stores; a pixel step runs a calculate state and then the emit state,
// and a drain step makes three store reads before the emit state.
// It starts a transaction only once the result buffer is empty, so after a pixel
// that yields two results the next transaction waits until both are read.
// When the receiver stalls, results hold in the buffer, the engine waits and
// the input queue fills, then req_chan.ready drops.
// Reset is synchronous and sets width and height to 1 and clears position and
// drain state; line store contents are not cleared and need no clearing pass.
module box_filter_3x3_edge_mean_core import bf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bf_req_if.sink    req_chan,
   bf_rsp_if.source  rsp_chan,
   bf_csr_if.sink    csr_chan
);

   logic      q_valid;
   item_type  q_item;
   logic      q_pop;
   logic      out_empty;
   push_type  push;

   // Input queue.
   bf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   // Filter engine with line stores and configuration.
   bf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_empty (out_empty),
      .push      (push)
   );

   // Result buffer.
   bf_out u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .rsp_chan (rsp_chan),
      .empty    (out_empty)
   );

endmodule
